// File: hw/rtl/dsn_pkg.sv
// Shared types, constants and helpers for the depth surface normal block.
package dsn_pkg;

    localparam int DSN_MAX_WIDTH  = 2048;
    localparam int DSN_DEPTH_BITS = 16;
    localparam int DEPTH_MAX_W    = 24;
    localparam int COL_W          = 13;
    localparam int ROW_W          = 11;
    localparam int PADDR_W        = 5;
    localparam int MAX_HEIGHT     = 2048;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_PU     = 3'd2,
        REG_PV     = 3'd3,
        REG_RA     = 3'd4,
        REG_RB     = 3'd5,
        REG_SKEW   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [11:0]        width;
        logic [11:0]        height;
        logic [15:0]        pu;
        logic [15:0]        pv;
        logic [23:0]        ra;
        logic [23:0]        rb;
        logic signed [19:0] skew;
    } cfg_t;

    // One window handed from the front to the back
    typedef struct packed {
        logic [8:0][DEPTH_MAX_W-1:0] win;
        logic [COL_W-1:0]            col;
        logic [ROW_W-1:0]            row;
        logic                        border;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_ADDR,
        BK_MUL,
        BK_SUM,
        BK_SCALE,
        BK_ACC,
        BK_XMUL,
        BK_XACC,
        BK_DONE
    } back_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -hi - 64'sd1;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        lo = -hi - 64'sd1;
        if (v > hi)
            return 48'sh7FFF_FFFF_FFFF;
        else if (v < lo)
            return 48'sh8000_0000_0000;
        else
            return v[47:0];
    endfunction

endpackage

// File: hw/rtl/dsn_if.sv
// Request channels for depth pixels and surface normals.
interface dsn_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth;
    logic        frame_start;

    modport source (output valid, output depth, output frame_start, input ready);
    modport sink (input valid, input depth, input frame_start, output ready);
endinterface

interface dsn_nrm_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] normal_x;
    logic signed [47:0] normal_y;
    logic signed [47:0] normal_z;
    logic [10:0]        centre_col;
    logic [10:0]        centre_row;
    logic               on_border;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output centre_col, output centre_row, output on_border, input ready);
    modport sink (input valid, input normal_x, input normal_y, input normal_z,
                  input centre_col, input centre_row, input on_border, output ready);
endinterface

// File: hw/rtl/dsn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsn_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/dsn_front.sv
// Front end: pixel intake, line stores, 3x3 window and window classification.
module dsn_front #(
    parameter int MAX_WIDTH  = dsn_pkg::DSN_MAX_WIDTH,
    parameter int DEPTH_BITS = dsn_pkg::DSN_DEPTH_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dsn_pkg::cfg_t  cfg,
    dsn_pix_if.sink        pix,
    input  logic           q_full,
    output logic           q_push,
    output dsn_pkg::job_t  q_job
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = 14;

    logic                  busy_reg;
    logic [CW-1:0]         col_reg;
    logic [dsn_pkg::ROW_W-1:0] row_reg;
    logic [CW-1:0]         col_s_reg;
    logic [dsn_pkg::ROW_W-1:0] row_s_reg;
    logic [DEPTH_BITS-1:0] d_reg;
    logic [2:0][2:0][DEPTH_BITS-1:0] win_reg;
    logic [2:0][2:0][DEPTH_BITS-1:0] win_next;

    logic                  accept;
    logic [CW-1:0]         col_c;
    logic [dsn_pkg::ROW_W-1:0] row_c;
    logic [dsn_pkg::DEPTH_MAX_W-1:0] dext;
    logic [DEPTH_BITS-1:0] up_rd;
    logic [DEPTH_BITS-1:0] mid_rd;
    logic [WW-1:0]         wc;
    logic [11:0]           hc;
    logic [WW-1:0]         col_w;
    logic [11:0]           row_w;
    logic                  emit;

    assign pix.ready = !busy_reg && !q_full;
    assign accept    = pix.valid && pix.ready;
    assign col_c     = pix.frame_start ? '0 : col_reg;
    assign row_c     = pix.frame_start ? '0 : row_reg;
    assign dext      = {8'b0, pix.depth};

    // Clamp frame size to the supported range
    always_comb
    begin
        if (cfg.width < 12'd3)
            wc = WW'(3);
        else if (WW'(cfg.width) > WW'(MAX_WIDTH))
            wc = WW'(MAX_WIDTH);
        else
            wc = WW'(cfg.width);
        if (cfg.height < 12'd3)
            hc = 12'd3;
        else if (cfg.height > 12'(dsn_pkg::MAX_HEIGHT))
            hc = 12'(dsn_pkg::MAX_HEIGHT);
        else
            hc = cfg.height;
    end

    // Line stores: rows two above and one above the incoming pixel
    dsn_ram #(.W(DEPTH_BITS), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (busy_reg),
        .waddr (col_s_reg),
        .wdata (mid_rd),
        .raddr (col_c),
        .rdata (up_rd)
    );

    dsn_ram #(.W(DEPTH_BITS), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (busy_reg),
        .waddr (col_s_reg),
        .wdata (d_reg),
        .raddr (col_c),
        .rdata (mid_rd)
    );

    // Shift the window one column left and insert the new column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_rd;
        win_next[1][2] = mid_rd;
        win_next[2][2] = d_reg;
    end

    // Classify the window and build the request for the back end
    assign col_w = WW'(col_s_reg);
    assign row_w = 12'(row_s_reg);
    assign emit  = (col_s_reg != '0) && (row_s_reg != '0) && (col_w < wc) && (row_w < hc);
    assign q_push = busy_reg && emit;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                q_job.win[r*3+c] = dsn_pkg::DEPTH_MAX_W'(win_next[r][c]);
            end
        end
        q_job.col    = dsn_pkg::COL_W'(col_s_reg);
        q_job.row    = row_s_reg;
        q_job.border = (col_s_reg == CW'(1)) || (row_s_reg == dsn_pkg::ROW_W'(1));
    end

    // Control: accept, then write back and advance counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            win_reg  <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
            win_reg  <= win_next;
            if (col_w + WW'(1) >= wc)
            begin
                col_reg <= '0;
                row_reg <= (row_w + 12'd1 >= hc) ? '0 : row_s_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_s_reg + 1'b1;
                row_reg <= row_s_reg;
            end
        end
    end

    // Hold the accepted pixel for the write-back cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_s_reg <= col_c;
            row_s_reg <= row_c;
            d_reg     <= dext[DEPTH_BITS-1:0];
        end
    end
endmodule

// File: hw/rtl/dsn_queue.sv
// Two-entry queue of window requests between front and back.
module dsn_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dsn_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output dsn_pkg::job_t head
);
    dsn_pkg::job_t ent_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign valid = cnt_reg != 2'd0;
    assign head  = ent_reg[rptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= push_job;
        end
    end
endmodule

// File: hw/rtl/dsn_back.sv
// Back end: back-projection, Sobel gradients, cross product and output register.
module dsn_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dsn_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  dsn_pkg::job_t q_job,
    output logic          q_pop,
    dsn_nrm_if.source     nrm
);
    dsn_pkg::back_state_t state_reg;
    dsn_pkg::back_state_t state_next;
    logic                 out_load;
    logic                 ov_reg;

    dsn_pkg::job_t        job_reg;
    logic [3:0]           k_reg;
    logic [1:0]           r_reg;
    logic [1:0]           c_reg;
    logic [2:0]           j_reg;

    logic signed [38:0]   m1_reg;
    logic signed [43:0]   syp_reg;
    logic signed [53:0]   pl_reg;
    logic signed [53:0]   ph_reg;
    logic signed [35:0]   sy_reg;
    logic signed [41:0]   sx_reg;
    logic signed [66:0]   xp_reg;
    logic signed [60:0]   yp_reg;
    logic signed [35:0]   acc_reg [6];
    logic signed [63:0]   prod_reg;
    logic signed [64:0]   t_reg;
    logic signed [47:0]   n_reg [3];

    logic signed [47:0]   onx_reg;
    logic signed [47:0]   ony_reg;
    logic signed [47:0]   onz_reg;
    logic [10:0]          ocol_reg;
    logic [10:0]          orow_reg;
    logic                 obrd_reg;

    logic [dsn_pkg::COL_W-1:0] u;
    logic [dsn_pkg::COL_W-1:0] v;
    logic signed [18:0]   dup;
    logic signed [18:0]   dvp;
    logic signed [40:0]   a_c;
    logic signed [65:0]   full_c;
    logic signed [24:0]   d_s;
    logic signed [33:0]   z_c;
    logic signed [66:0]   xs_c;
    logic signed [60:0]   ys_c;
    logic signed [35:0]   ex;
    logic signed [35:0]   ey;
    logic signed [35:0]   ez;
    logic signed [35:0]   wu [3];
    logic signed [35:0]   wv [3];
    logic signed [31:0]   dg [6];
    logic signed [31:0]   opa;
    logic signed [31:0]   opb;
    logic signed [65:0]   diff_c;
    logic signed [65:0]   dsh_c;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsn_pkg::BK_IDLE:  if (q_valid)
                                   state_next = q_job.border ? dsn_pkg::BK_DONE
                                                             : dsn_pkg::BK_ADDR;
            dsn_pkg::BK_ADDR:  state_next = dsn_pkg::BK_MUL;
            dsn_pkg::BK_MUL:   state_next = dsn_pkg::BK_SUM;
            dsn_pkg::BK_SUM:   state_next = dsn_pkg::BK_SCALE;
            dsn_pkg::BK_SCALE: state_next = dsn_pkg::BK_ACC;
            dsn_pkg::BK_ACC:   state_next = (k_reg == 4'd8) ? dsn_pkg::BK_XMUL
                                                            : dsn_pkg::BK_ADDR;
            dsn_pkg::BK_XMUL:  state_next = dsn_pkg::BK_XACC;
            dsn_pkg::BK_XACC:  state_next = (j_reg == 3'd5) ? dsn_pkg::BK_DONE
                                                            : dsn_pkg::BK_XMUL;
            dsn_pkg::BK_DONE:  if (out_load)
                                   state_next = dsn_pkg::BK_IDLE;
            default:           state_next = dsn_pkg::BK_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            dsn_pkg::BK_IDLE: q_pop    = q_valid;
            dsn_pkg::BK_DONE: out_load = !ov_reg || nrm.ready;
            default:
            begin
                q_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Pixel coordinates of the current window point
    assign u   = job_reg.col - dsn_pkg::COL_W'(2) + dsn_pkg::COL_W'(c_reg);
    assign v   = dsn_pkg::COL_W'(job_reg.row) - dsn_pkg::COL_W'(2) + dsn_pkg::COL_W'(r_reg);
    assign dup = $signed({2'b0, u, 4'b0}) - $signed({3'b0, cfg.pu});
    assign dvp = $signed({2'b0, v, 4'b0}) - $signed({3'b0, cfg.pv});
    assign a_c = (41'(dup) <<< 16) - 41'(m1_reg);
    assign full_c = (66'(ph_reg) <<< 12) + 66'(pl_reg);
    assign d_s  = $signed({1'b0, job_reg.win[k_reg]});
    assign z_c  = -$signed({2'b0, job_reg.win[k_reg], 8'b0});
    assign xs_c = xp_reg >>> 12;
    assign ys_c = yp_reg >>> 12;
    assign ex   = 36'(dsn_pkg::sat32(xs_c[63:0]));
    assign ey   = 36'(dsn_pkg::sat32(64'(ys_c)));
    assign ez   = 36'(dsn_pkg::sat32(64'(z_c)));

    // Sobel weights of the current point
    always_comb
    begin
        logic signed [35:0] p [3];
        p[0] = ex;
        p[1] = ey;
        p[2] = ez;
        for (int i = 0; i < 3; i++)
        begin
            if (c_reg == 2'd2)
                wu[i] = (r_reg == 2'd1) ? (p[i] <<< 1) : p[i];
            else if (c_reg == 2'd0)
                wu[i] = (r_reg == 2'd1) ? -(p[i] <<< 1) : -p[i];
            else
                wu[i] = '0;
            if (r_reg == 2'd2)
                wv[i] = (c_reg == 2'd1) ? (p[i] <<< 1) : p[i];
            else if (r_reg == 2'd0)
                wv[i] = (c_reg == 2'd1) ? -(p[i] <<< 1) : -p[i];
            else
                wv[i] = '0;
        end
    end

    // Gradients: du x,y,z then dv x,y,z
    always_comb
    begin
        logic signed [35:0] sh;
        for (int i = 0; i < 6; i++)
        begin
            sh    = acc_reg[i] >>> 3;
            dg[i] = dsn_pkg::sat32(64'(sh));
        end
    end

    // Cross product operand selection
    always_comb
    begin
        case (j_reg)
            3'd0:    begin opa = dg[1]; opb = dg[5]; end
            3'd1:    begin opa = dg[2]; opb = dg[4]; end
            3'd2:    begin opa = dg[2]; opb = dg[3]; end
            3'd3:    begin opa = dg[0]; opb = dg[5]; end
            3'd4:    begin opa = dg[0]; opb = dg[4]; end
            3'd5:    begin opa = dg[1]; opb = dg[3]; end
            default: begin opa = '0;    opb = '0;    end
        endcase
    end

    assign diff_c = 66'(t_reg) - 66'(prod_reg);
    assign dsh_c  = diff_c >>> 8;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsn_pkg::BK_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (nrm.ready)
                ov_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            dsn_pkg::BK_IDLE:
            begin
                job_reg <= q_job;
                k_reg   <= '0;
                r_reg   <= '0;
                c_reg   <= '0;
                j_reg   <= '0;
                for (int i = 0; i < 6; i++)
                    acc_reg[i] <= '0;
                for (int i = 0; i < 3; i++)
                    n_reg[i] <= '0;
            end
            dsn_pkg::BK_ADDR:
            begin
                m1_reg  <= dvp * cfg.skew;
                syp_reg <= dvp * $signed({1'b0, cfg.rb});
            end
            dsn_pkg::BK_MUL:
            begin
                pl_reg <= a_c * $signed({1'b0, cfg.ra[11:0]});
                ph_reg <= a_c * $signed({1'b0, cfg.ra[23:12]});
                sy_reg <= 36'(syp_reg >>> 8);
            end
            dsn_pkg::BK_SUM:
            begin
                sx_reg <= 42'(full_c >>> 24);
            end
            dsn_pkg::BK_SCALE:
            begin
                xp_reg <= sx_reg * d_s;
                yp_reg <= sy_reg * d_s;
            end
            dsn_pkg::BK_ACC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_reg[i]   <= acc_reg[i] + wu[i];
                    acc_reg[i+3] <= acc_reg[i+3] + wv[i];
                end
                k_reg <= k_reg + 4'd1;
                if (c_reg == 2'd2)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 2'd1;
                end
                else
                begin
                    c_reg <= c_reg + 2'd1;
                end
            end
            dsn_pkg::BK_XMUL:
            begin
                prod_reg <= opa * opb;
            end
            dsn_pkg::BK_XACC:
            begin
                if (!j_reg[0])
                    t_reg <= 65'(prod_reg);
                else
                    n_reg[j_reg[2:1]] <= dsn_pkg::sat48(dsh_c[63:0]);
                j_reg <= j_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            onx_reg  <= n_reg[0];
            ony_reg  <= n_reg[1];
            onz_reg  <= n_reg[2];
            ocol_reg <= 11'(job_reg.col - dsn_pkg::COL_W'(1));
            orow_reg <= job_reg.row - 11'd1;
            obrd_reg <= job_reg.border;
        end
    end

    assign nrm.valid      = ov_reg;
    assign nrm.normal_x   = onx_reg;
    assign nrm.normal_y   = ony_reg;
    assign nrm.normal_z   = onz_reg;
    assign nrm.centre_col = ocol_reg;
    assign nrm.centre_row = orow_reg;
    assign nrm.on_border  = obrd_reg;
endmodule

// File: hw/rtl/depth_surface_normal_sobel.sv
// Top level of the depth image surface normal block.
//
// Depth pixels arrive in raster order on the pix request channel; frame_start
// marks pixel (0,0). Normals leave on the nrm channel, one for each pixel whose
// window centre lies inside the frame but off its last row and last column.
// Border centres come out with on_border set and zero normal fields.
// The front takes a pixel by a line store read, then the write back and window
// shift, taking no new pixel until the write back is done. Complete windows go
// to a two-entry queue. The back works one window at a time: the nine points
// go through its shared multipliers in turn, then the cross product; border
// windows skip to the done state. Pixels that give no result never reach the
// back. When the receiver stalls the result waits in the output register, the
// back finishes its next window, then the queue fills and pix.ready drops.
// Reset clears counters, window, queue and output valid and loads the default
// camera settings; line store contents stay undefined until written. Registers
// are written through the APB port; the user must do so only while the block
// is idle, which the block itself does not enforce.
module depth_surface_normal_sobel #(
    parameter int MAX_WIDTH  = dsn_pkg::DSN_MAX_WIDTH,
    parameter int DEPTH_BITS = dsn_pkg::DSN_DEPTH_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dsn_pix_if.sink                     pix,
    dsn_nrm_if.source                   nrm,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsn_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    dsn_pkg::cfg_t    cfg_reg;
    dsn_pkg::reg_idx_t widx;
    logic             wr_en;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    dsn_pkg::job_t    push_job;
    dsn_pkg::job_t    head_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = dsn_pkg::reg_idx_t'(paddr[4:2]);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= 12'd640;
            cfg_reg.height <= 12'd480;
            cfg_reg.pu     <= 16'd5120;
            cfg_reg.pv     <= 16'd3840;
            cfg_reg.ra     <= 24'd32768;
            cfg_reg.rb     <= 24'd32768;
            cfg_reg.skew   <= '0;
        end
        else if (wr_en)
        begin
            case (widx)
                dsn_pkg::REG_WIDTH:  cfg_reg.width  <= pwdata[11:0];
                dsn_pkg::REG_HEIGHT: cfg_reg.height <= pwdata[11:0];
                dsn_pkg::REG_PU:     cfg_reg.pu     <= pwdata[15:0];
                dsn_pkg::REG_PV:     cfg_reg.pv     <= pwdata[15:0];
                dsn_pkg::REG_RA:     cfg_reg.ra     <= pwdata[23:0];
                dsn_pkg::REG_RB:     cfg_reg.rb     <= pwdata[23:0];
                dsn_pkg::REG_SKEW:   cfg_reg.skew   <= pwdata[19:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (widx)
            dsn_pkg::REG_WIDTH:  prdata = 32'(cfg_reg.width);
            dsn_pkg::REG_HEIGHT: prdata = 32'(cfg_reg.height);
            dsn_pkg::REG_PU:     prdata = 32'(cfg_reg.pu);
            dsn_pkg::REG_PV:     prdata = 32'(cfg_reg.pv);
            dsn_pkg::REG_RA:     prdata = 32'(cfg_reg.ra);
            dsn_pkg::REG_RB:     prdata = 32'(cfg_reg.rb);
            dsn_pkg::REG_SKEW:   prdata = {12'b0, cfg_reg.skew};
            default:             prdata = '0;
        endcase
    end

    dsn_front #(.MAX_WIDTH(MAX_WIDTH), .DEPTH_BITS(DEPTH_BITS)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pix    (pix),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    dsn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_job)
    );

    dsn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .nrm     (nrm)
    );

    // Queue never takes a request when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("window queue overflow");

    // Queue never pops when empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("window queue underflow");

    // Front is busy for the cycle after an accepted pixel
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) |=> !pix.ready)
        else $error("pixel accepted during write back");

    // Border results carry a zero normal
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (nrm.valid && nrm.on_border) |->
            (nrm.normal_x == '0 && nrm.normal_y == '0 && nrm.normal_z == '0))
        else $error("border result with nonzero normal");
endmodule

// File: verif/tb_depth_surface_normal_sobel.sv
// Testbench for the depth surface normal block: random pixel streams checked against a predictor.
`timescale 1ns / 100ps
module tb_depth_surface_normal_sobel;

    typedef struct {
        logic [15:0] depth;
        logic        frame_start;
    } pixel_t;

    typedef struct {
        logic signed [47:0] nx;
        logic signed [47:0] ny;
        logic signed [47:0] nz;
        logic [10:0]        col;
        logic [10:0]        row;
        logic               border;
    } normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [dsn_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    dsn_pix_if pix ();
    dsn_nrm_if nrm ();

    depth_surface_normal_sobel DUT (
        .clk(clk), .rst_n(rst_n), .pix(pix), .nrm(nrm),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Predictor state: camera settings, line stores, window and counters
    logic [11:0] cam_width = 12'd640, cam_height = 12'd480;
    logic [15:0] cam_pu = 16'd5120, cam_pv = 16'd3840;
    logic [23:0] cam_ra = 24'd32768, cam_rb = 24'd32768;
    logic signed [19:0] cam_skew = '0;
    logic [15:0] store_up [0:2047];
    logic [15:0] store_mid [0:2047];
    logic [15:0] win [0:2][0:2];
    int unsigned cur_col = 0, cur_row = 0;

    pixel_t  pending_pixels [$];
    normal_t expected_normals [$];
    int errors = 0;
    int normals_seen = 0;
    int borders_seen = 0;
    int pixels_sent = 0;
    longint cycles = 0;
    bit no_idle = 1'b0;

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clampv(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    // Back-project one pixel to a Q24.8 point
    function automatic void to_point(longint u, longint v, longint d,
                                     output longint px, output longint py,
                                     output longint pz);
        longint dup, dvp, a, sx, sy;
        dup = u * 16 - longint'(cam_pu);
        dvp = v * 16 - longint'(cam_pv);
        a = dup * 65536 - dvp * longint'(cam_skew);
        sx = fshr(a * longint'(cam_ra), 24);
        sy = fshr(dvp * longint'(cam_rb), 8);
        px = clampv(fshr(sx * d, 12), 32);
        py = clampv(fshr(sy * d, 12), 32);
        pz = clampv(-(d * 256), 32);
    endfunction

    function automatic longint grad(longint a, longint b, longint m,
                                    longint c, longint e, longint n);
        return clampv(fshr(a + b + 2 * m - c - e - 2 * n, 3), 32);
    endfunction

    // Advance the predictor by one pixel; queue the normal it produces
    task automatic predict_normal(pixel_t p);
        int unsigned w, h, col, row;
        logic [15:0] up, mid;
        longint px [0:2][0:2], py [0:2][0:2], pz [0:2][0:2];
        longint dux, duy, duz, dvx, dvy, dvz;
        normal_t r;
        w = cam_width < 3 ? 3 : (cam_width > 2048 ? 2048 : cam_width);
        h = cam_height < 3 ? 3 : (cam_height > 2048 ? 2048 : cam_height);
        if (p.frame_start)
        begin
            cur_col = 0;
            cur_row = 0;
        end
        col = cur_col;
        row = cur_row;
        up = store_up[col];
        mid = store_mid[col];
        store_up[col] = mid;
        store_mid[col] = p.depth;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = p.depth;
        if (col >= 1 && row >= 1 && col < w && row < h)
        begin
            r.nx = 0; r.ny = 0; r.nz = 0;
            r.border = (col == 1 || row == 1);
            if (!r.border)
            begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        to_point(longint'(col) - 2 + j, longint'(row) - 2 + i,
                                 longint'(win[i][j]), px[i][j], py[i][j], pz[i][j]);
                dux = grad(px[0][2], px[2][2], px[1][2], px[0][0], px[2][0], px[1][0]);
                duy = grad(py[0][2], py[2][2], py[1][2], py[0][0], py[2][0], py[1][0]);
                duz = grad(pz[0][2], pz[2][2], pz[1][2], pz[0][0], pz[2][0], pz[1][0]);
                dvx = grad(px[2][0], px[2][2], px[2][1], px[0][0], px[0][2], px[0][1]);
                dvy = grad(py[2][0], py[2][2], py[2][1], py[0][0], py[0][2], py[0][1]);
                dvz = grad(pz[2][0], pz[2][2], pz[2][1], pz[0][0], pz[0][2], pz[0][1]);
                r.nx = clampv(fshr(duy * dvz - duz * dvy, 8), 48);
                r.ny = clampv(fshr(duz * dvx - dux * dvz, 8), 48);
                r.nz = clampv(fshr(dux * dvy - duy * dvx, 8), 48);
            end
            r.col = col - 1;
            r.row = row - 1;
            expected_normals.push_back(r);
        end
        if (col + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (row + 1 >= h) ? 0 : row + 1;
        end
        else
            cur_col = col + 1;
    endtask

    // Driver: present the next pending pixel, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid <= 1'b0;
            pix.depth <= '0;
            pix.frame_start <= 1'b0;
        end
        else
        begin
            if (!pix.valid || pix.ready)
            begin
                if (pix.valid && pix.ready)
                    void'(pending_pixels.pop_front());
                if (pending_pixels.size() > 0 &&
                    (no_idle || $urandom_range(99) >= 20))
                begin
                    pix.valid <= 1'b1;
                    pix.depth <= pending_pixels[0].depth;
                    pix.frame_start <= pending_pixels[0].frame_start;
                end
                else
                    pix.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result side at random, check each accepted normal
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nrm.ready <= 1'b0;
        else
        begin
            cycles <= cycles + 1;
            nrm.ready <= no_idle || $urandom_range(99) >= 20;
            if (nrm.valid && nrm.ready)
            begin
                if (expected_normals.size() == 0)
                begin
                    $display("%0t: unexpected normal col %0d row %0d", $time,
                             nrm.centre_col, nrm.centre_row);
                    errors++;
                end
                else
                begin
                    normal_t e;
                    e = expected_normals.pop_front();
                    normals_seen++;
                    if (e.border)
                        borders_seen++;
                    if (nrm.normal_x !== e.nx || nrm.normal_y !== e.ny ||
                        nrm.normal_z !== e.nz || nrm.centre_col !== e.col ||
                        nrm.centre_row !== e.row || nrm.on_border !== e.border)
                    begin
                        $display("%0t: mismatch expected (%0d %0d %0d) c%0d r%0d b%0d",
                                 $time, e.nx, e.ny, e.nz, e.col, e.row, e.border);
                        $display("%0t:            actual (%0d %0d %0d) c%0d r%0d b%0d",
                                 $time, nrm.normal_x, nrm.normal_y, nrm.normal_z,
                                 nrm.centre_col, nrm.centre_row, nrm.on_border);
                        errors++;
                    end
                end
            end
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        if (cycles > 3000000)
        begin
            $display("Timeout with %0d normals outstanding", expected_normals.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic reg_write(dsn_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= dsn_pkg::PADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            dsn_pkg::REG_WIDTH:  cam_width = value[11:0];
            dsn_pkg::REG_HEIGHT: cam_height = value[11:0];
            dsn_pkg::REG_PU:     cam_pu = value[15:0];
            dsn_pkg::REG_PV:     cam_pv = value[15:0];
            dsn_pkg::REG_RA:     cam_ra = value[23:0];
            dsn_pkg::REG_RB:     cam_rb = value[23:0];
            dsn_pkg::REG_SKEW:   cam_skew = value[19:0];
            default: ;
        endcase
    endtask

    // Queue one pixel and predict what it yields
    task automatic add_pixel(logic [15:0] d, logic fs);
        pixel_t p;
        p.depth = d;
        p.frame_start = fs;
        pending_pixels.push_back(p);
        pixels_sent++;
        predict_normal(p);
    endtask

    // Wait until all requests are accepted and all normals have come out
    task automatic drain();
        wait (pending_pixels.size() == 0 && expected_normals.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    // Queue whole frames; mostly smooth depth ramps, some noise and extremes
    task automatic add_frames(int nframes, int w, int h);
        int kind;
        logic [15:0] base;
        for (int f = 0; f < nframes; f++)
        begin
            kind = $urandom_range(9);
            base = $urandom;
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                begin
                    logic [15:0] d;
                    case (kind)
                        0: d = $urandom;
                        1: d = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                        default: d = base + 16'(r * 37 + c * 11) + 16'($urandom_range(7));
                    endcase
                    add_pixel(d, r == 0 && c == 0);
                end
        end
    endtask

    task automatic set_camera(logic [11:0] w, logic [11:0] h);
        reg_write(dsn_pkg::REG_WIDTH, w);
        reg_write(dsn_pkg::REG_HEIGHT, h);
        reg_write(dsn_pkg::REG_PU, $urandom_range(65535));
        reg_write(dsn_pkg::REG_PV, $urandom_range(65535));
        reg_write(dsn_pkg::REG_RA, $urandom_range(24'hFFFFFF));
        reg_write(dsn_pkg::REG_RB, $urandom_range(24'hFFFFFF));
        reg_write(dsn_pkg::REG_SKEW, $urandom_range(20'hFFFFF));
    endtask

    initial
    begin
        // Predictor starts from cleared stores and window
        for (int i = 0; i < 2048; i++)
        begin
            store_up[i] = '0;
            store_mid[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: smallest frame with extreme depths under the reset camera
        reg_write(dsn_pkg::REG_WIDTH, 12'd3);
        reg_write(dsn_pkg::REG_HEIGHT, 12'd3);
        for (int i = 0; i < 9; i++)
            add_pixel(i == 4 ? 16'hFFFF : 16'h0000, i == 0);
        for (int i = 0; i < 9; i++)
            add_pixel(i[0] ? 16'hFFFF : 16'h0001, i == 0);
        drain();

        // Directed: extreme intrinsics, clamped width and height of zero
        reg_write(dsn_pkg::REG_WIDTH, 12'd0);
        reg_write(dsn_pkg::REG_HEIGHT, 12'd0);
        reg_write(dsn_pkg::REG_PU, 16'hFFFF);
        reg_write(dsn_pkg::REG_PV, 16'h0000);
        reg_write(dsn_pkg::REG_RA, 24'hFFFFFF);
        reg_write(dsn_pkg::REG_RB, 24'hFFFFFF);
        reg_write(dsn_pkg::REG_SKEW, 32'hFFF80000);
        add_frames(1, 3, 3);
        drain();
        reg_write(dsn_pkg::REG_SKEW, 20'h7FFFF);
        reg_write(dsn_pkg::REG_PU, 16'h0000);
        reg_write(dsn_pkg::REG_PV, 16'hFFFF);
        add_frames(1, 3, 3);
        drain();

        // Random frames under several camera settings, small sizes mostly
        for (int phase = 0; phase < 12; phase++)
        begin
            int w, h;
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            set_camera(12'(w), 12'(h));
            no_idle = (phase == 6);
            add_frames($urandom_range(1, 2), w, h);
            // Noise: pixels without a frame start, continuing the raster
            if (phase % 3 == 1)
                for (int i = 0; i < 10; i++)
                    add_pixel($urandom, 1'b0);
            drain();
        end
        no_idle = 1'b0;

        // Oversized width clamps to the widest line; first row only
        set_camera(12'hFFF, 12'd3);
        for (int i = 0; i < 250; i++)
            add_pixel($urandom, i == 0);
        drain();

        // Shrink the width mid-line so the column counter lies beyond it
        set_camera(12'd10, 12'd6);
        add_frames(1, 10, 2);
        for (int i = 0; i < 7; i++)
            add_pixel($urandom, 1'b0);
        drain();
        reg_write(dsn_pkg::REG_WIDTH, 12'd4);
        for (int i = 0; i < 12; i++)
            add_pixel($urandom, 1'b0);
        drain();

        $display("Sent %0d pixels over random frame sizes, camera settings and width changes",
                 pixels_sent);
        $display("Checked %0d normals, %0d of them on the border", normals_seen, borders_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
